// File: hw/rtl/fmr_pkg.sv
package fmr_pkg;

	localparam int unsigned MAX_LENGTH = 2047;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned CNT_W      = 12;
	localparam int unsigned CFG_IDX_W  = 8;

	localparam logic [7:0] START_BYTE   = 8'h24;
	localparam logic [7:0] ACK_RESET    = 8'd6;
	localparam logic [7:0] BAD_RESET    = 8'd21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACK_CODE = 8'd0,
		CFG_BAD_CODE = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       select_low;
	} rx_item_t;

	typedef struct packed {
		logic             store_valid;
		logic [LEN_W-1:0] store_index;
		logic [7:0]       store_data;
		logic             reply_valid;
		logic [7:0]       reply_byte;
		logic             message_ready;
		logic [LEN_W-1:0] message_length;
	} res_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           value;
	} cfg_item_t;

endpackage

// File: hw/rtl/fmr_if.sv
interface fmr_rx_if;
	logic              valid;
	logic              ready;
	fmr_pkg::rx_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmr_res_if;
	logic               valid;
	logic               ready;
	fmr_pkg::res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmr_cfg_if;
	logic               valid;
	logic               ready;
	fmr_pkg::cfg_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/framed_message_receiver.sv
// a request passes through the input register and then the result register before its result is valid
// throughput: one request per cycle while the result side is ready; the frame state updates in one step per byte
// the input register takes a new request whenever the result register is free or draining
// reset (arst_n low, asynchronous): idle, no frame open, counters and sums cleared,
// ack code 6, bad code 21, both pipeline stages empty
module framed_message_receiver (
	input  logic           clk,
	input  logic           arst_n,
	fmr_rx_if.sink         rx,
	fmr_res_if.source      res,
	fmr_cfg_if.sink        cfg
);
	import fmr_pkg::*;

	logic [7:0]       ack_code_q;
	logic [7:0]       bad_code_q;

	logic             in_frame_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic [LEN_W-1:0] frame_len_q;
	logic [7:0]       exp_sum_q;
	logic [7:0]       run_sum_q;

	logic             in_frame_n;
	logic [CNT_W-1:0] byte_cnt_n;
	logic [LEN_W-1:0] frame_len_n;
	logic [7:0]       exp_sum_n;
	logic [7:0]       run_sum_n;

	logic             vld_s1;
	rx_item_t         rx_s1;
	logic             vld_s2;
	res_item_t        res_s2;
	res_item_t        res_n;

	logic             adv_s1;
	logic [CNT_W-1:0] cnt_inc;
	logic [15:0]      len_full;
	logic             done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q <= ACK_RESET;
			bad_code_q <= BAD_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_ACK_CODE: ack_code_q <= cfg.data.value;
				CFG_BAD_CODE: bad_code_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	assign adv_s1   = vld_s1 && (!vld_s2 || res.ready);
	assign rx.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_s1 <= rx.data;
		end
	end

	// frame parser
	assign cnt_inc  = byte_cnt_q + CNT_W'(1);
	assign len_full = {frame_len_q[7:0], rx_s1.data_byte};

	always_comb begin
		in_frame_n  = in_frame_q;
		byte_cnt_n  = byte_cnt_q;
		frame_len_n = frame_len_q;
		exp_sum_n   = exp_sum_q;
		run_sum_n   = run_sum_q;
		res_n       = '0;
		done        = 1'b0;
		if (!in_frame_q) begin
			if (rx_s1.select_low && rx_s1.data_byte == START_BYTE) begin
				in_frame_n  = 1'b1;
				byte_cnt_n  = '0;
				frame_len_n = '0;
				exp_sum_n   = '0;
				run_sum_n   = '0;
			end
		end else begin
			byte_cnt_n = cnt_inc;
			case (byte_cnt_q)
				CNT_W'(0): exp_sum_n = rx_s1.data_byte;
				CNT_W'(1): frame_len_n = LEN_W'(rx_s1.data_byte);
				CNT_W'(2): begin
					if (len_full > 16'(MAX_LENGTH)) begin
						frame_len_n = LEN_W'(MAX_LENGTH);
					end else begin
						frame_len_n = len_full[LEN_W-1:0];
					end
					res_n.message_length = frame_len_n;
				end
				default: begin
					res_n.message_length = frame_len_q;
					if (frame_len_q != '0) begin
						res_n.store_valid = 1'b1;
						res_n.store_index = LEN_W'(byte_cnt_q - CNT_W'(3));
						res_n.store_data  = rx_s1.data_byte;
						run_sum_n         = run_sum_q + rx_s1.data_byte;
					end
					done = cnt_inc > ({1'b0, frame_len_q} + CNT_W'(2));
					if (done) begin
						res_n.reply_valid   = 1'b1;
						res_n.message_ready = (run_sum_n == exp_sum_q);
						res_n.reply_byte    = (run_sum_n == exp_sum_q) ? ack_code_q
						                                                : bad_code_q;
						in_frame_n  = 1'b0;
						byte_cnt_n  = '0;
						frame_len_n = '0;
						exp_sum_n   = '0;
						run_sum_n   = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			byte_cnt_q  <= '0;
			frame_len_q <= '0;
			exp_sum_q   <= '0;
			run_sum_q   <= '0;
		end else if (adv_s1) begin
			in_frame_q  <= in_frame_n;
			byte_cnt_q  <= byte_cnt_n;
			frame_len_q <= frame_len_n;
			exp_sum_q   <= exp_sum_n;
			run_sum_q   <= run_sum_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || res.ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_n;
		end
	end

	assign res.valid = vld_s2;
	assign res.data  = res_s2;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (byte_cnt_q == '0 && run_sum_q == '0 && frame_len_q == '0))
		else $error("frame state not cleared while idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_frame_q && byte_cnt_q > CNT_W'(3)) |->
		(byte_cnt_q <= {1'b0, frame_len_q} + CNT_W'(2)))
		else $error("byte counter ran past the frame end");

	a_ready_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.message_ready) |-> res.data.reply_valid)
		else $error("message ready without a reply");

	a_store_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.store_valid) |->
		(res.data.store_index < res.data.message_length))
		else $error("store index outside the frame length");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_n.reply_valid) |=> !in_frame_q)
		else $error("frame still open after its reply");

endmodule
